// ----- src/gl3_pkg.sv -----
`timescale 1ns / 1ps

package gl3_pkg;

  // Sample and weight formats
  localparam int SAMPLE_BITS          = 16;
  localparam int WEIGHT_FRACTION_BITS = 16;
  localparam int WF                   = WEIGHT_FRACTION_BITS;

  // Derived widths
  localparam int WEIGHT_BITS = WF;
  localparam int GAIN_BITS   = WF + 1;
  localparam int SUM_BITS    = SAMPLE_BITS + 2;         // sum of four samples
  localparam int PROD_BITS   = SUM_BITS + WEIGHT_BITS + 1;
  localparam int ACC_BITS    = SAMPLE_BITS + WF + 4;
  localparam int HI_BITS     = ACC_BITS - WF;
  localparam int PH_BITS     = HI_BITS + GAIN_BITS + 1;
  localparam int PL_BITS     = WF + GAIN_BITS;
  localparam int LP_BITS     = PL_BITS + 1 - WF;
  localparam int RSUM_BITS   = PH_BITS + 1;
  localparam int R_BITS      = RSUM_BITS - WF;

  localparam logic [PL_BITS:0] ROUND_BIAS = (PL_BITS + 1)'(1) << (2 * WF - 1);

  // Configuration register map
  localparam int CFG_DATA_BITS  = GAIN_BITS;
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIDE_WEIGHT     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DIAGONAL_WEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NORM_GAIN       = 2'd2;

  localparam logic [WEIGHT_BITS-1:0] SIDE_WEIGHT_RESET     = WEIGHT_BITS'(7548);
  localparam logic [WEIGHT_BITS-1:0] DIAGONAL_WEIGHT_RESET = WEIGHT_BITS'(4014);
  localparam logic [GAIN_BITS-1:0]   NORM_GAIN_RESET       = GAIN_BITS'(38422);

  // Job queue
  localparam int JOB_DEPTH    = 4;
  localparam int JOB_PTR_BITS = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_BITS = $clog2(JOB_DEPTH + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic [WEIGHT_BITS-1:0]        weight_t;
  typedef logic [GAIN_BITS-1:0]          gain_t;

  // One pixel to filter: kernel taps already folded into two sums
  typedef struct packed {
    sample_t centre;
    sum_t    side_sum;
    sum_t    diag_sum;
    logic    end_of_row;
  } filt_job_t;

  function automatic sum_t add4(sample_t a, sample_t b, sample_t c, sample_t d);
    return sum_t'(a) + sum_t'(b) + sum_t'(c) + sum_t'(d);
  endfunction

endpackage

// ----- src/gl3_front.sv -----
`timescale 1ns / 1ps

module gl3_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  gl3_pkg::sample_t    top_sample,
  input  gl3_pkg::sample_t    centre_sample,
  input  gl3_pkg::sample_t    bottom_sample,
  input  logic                last_in_row,
  input  logic                job_full,
  output logic                job_push,
  output gl3_pkg::filt_job_t  job_data
);

  // column window: [0] left column, [1] pending centre column
  gl3_pkg::sample_t   win_top [2];
  gl3_pkg::sample_t   win_centre [2];
  gl3_pkg::sample_t   win_bottom [2];
  logic               in_row;
  logic               pend_valid;
  gl3_pkg::filt_job_t pend_job;

  gl3_pkg::filt_job_t mid_job;
  gl3_pkg::filt_job_t edge_job;
  logic               accept;

  assign in_stall = pend_valid || job_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    mid_job.centre     = win_centre[1];
    mid_job.side_sum   = gl3_pkg::add4(win_top[1], win_bottom[1], win_centre[0],
                                       centre_sample);
    mid_job.diag_sum   = gl3_pkg::add4(win_top[0], top_sample, win_bottom[0],
                                       bottom_sample);
    mid_job.end_of_row = 1'b0;

    // right edge repeats this column; a one-pixel row repeats it on both sides
    edge_job.centre     = centre_sample;
    edge_job.end_of_row = 1'b1;
    if (in_row) begin
      edge_job.side_sum = gl3_pkg::add4(top_sample, bottom_sample, win_centre[1],
                                        centre_sample);
      edge_job.diag_sum = gl3_pkg::add4(win_top[1], top_sample, win_bottom[1],
                                        bottom_sample);
    end else begin
      edge_job.side_sum = gl3_pkg::add4(top_sample, bottom_sample, centre_sample,
                                        centre_sample);
      edge_job.diag_sum = gl3_pkg::add4(top_sample, top_sample, bottom_sample,
                                        bottom_sample);
    end
  end

  always_comb begin
    job_push = 1'b0;
    job_data = mid_job;
    priority if (pend_valid) begin
      job_push = !job_full;
      job_data = pend_job;
    end else if (accept && in_row) begin
      job_push = 1'b1;
      job_data = mid_job;
    end else if (accept && last_in_row) begin
      job_push = 1'b1;
      job_data = edge_job;
    end else begin
      // nothing to queue this cycle
      job_push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row     <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_valid && !job_full) begin
        pend_valid <= 1'b0;
      end
      if (accept) begin
        in_row <= !last_in_row;
        if (in_row && last_in_row) begin
          pend_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_job <= edge_job;
      if (in_row) begin
        win_top[0]    <= win_top[1];
        win_centre[0] <= win_centre[1];
        win_bottom[0] <= win_bottom[1];
      end else begin
        win_top[0]    <= top_sample;
        win_centre[0] <= centre_sample;
        win_bottom[0] <= bottom_sample;
      end
      win_top[1]    <= top_sample;
      win_centre[1] <= centre_sample;
      win_bottom[1] <= bottom_sample;
    end
  end

endmodule

// ----- src/gl3_job_fifo.sv -----
`timescale 1ns / 1ps

module gl3_job_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  gl3_pkg::filt_job_t  push_data,
  output logic                full,
  input  logic                pop,
  output gl3_pkg::filt_job_t  head,
  output logic                not_empty
);

  gl3_pkg::filt_job_t                 slots [gl3_pkg::JOB_DEPTH];
  logic [gl3_pkg::JOB_PTR_BITS-1:0]   wr_ptr;
  logic [gl3_pkg::JOB_PTR_BITS-1:0]   rd_ptr;
  logic [gl3_pkg::JOB_CNT_BITS-1:0]   count;
  logic                               do_push;
  logic                               do_pop;

  assign full      = count == gl3_pkg::JOB_CNT_BITS'(gl3_pkg::JOB_DEPTH);
  assign not_empty = count != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- src/gl3_back.sv -----
`timescale 1ns / 1ps

module gl3_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  gl3_pkg::filt_job_t  job,
  output logic                job_pop,
  input  gl3_pkg::weight_t    side_weight,
  input  gl3_pkg::weight_t    diagonal_weight,
  input  gl3_pkg::gain_t      norm_gain,
  output logic                out_valid,
  input  logic                out_stall,
  output gl3_pkg::sample_t    filtered_pixel,
  output logic                end_of_row
);

  localparam int S = gl3_pkg::SAMPLE_BITS;

  logic advance;

  // stage 1: weight products
  logic                                  v1;
  logic signed [gl3_pkg::PROD_BITS-1:0]  p_side;
  logic signed [gl3_pkg::PROD_BITS-1:0]  p_diag;
  gl3_pkg::sample_t                      c1;
  logic                                  e1;

  // stage 2: accumulated kernel sum
  logic                                  v2;
  logic signed [gl3_pkg::ACC_BITS-1:0]   acc;
  logic                                  e2;

  // stage 3: gain products on upper and lower halves
  logic                                  v3;
  logic signed [gl3_pkg::PH_BITS-1:0]    p_hi;
  logic [gl3_pkg::PL_BITS-1:0]           p_lo;
  logic                                  e3;

  // stage 4 (combinational into output register): round, shift, saturate
  logic [gl3_pkg::PL_BITS:0]             lo_rounded;
  logic [gl3_pkg::LP_BITS-1:0]           low_part;
  logic signed [gl3_pkg::RSUM_BITS-1:0]  rsum;
  logic signed [gl3_pkg::R_BITS-1:0]     r;
  logic                                  overflow;
  gl3_pkg::sample_t                      sat;

  assign advance = !(out_valid && out_stall);
  assign job_pop = advance && job_valid;

  always_comb begin
    lo_rounded = (gl3_pkg::PL_BITS + 1)'(p_lo) + gl3_pkg::ROUND_BIAS;
    low_part   = lo_rounded[gl3_pkg::PL_BITS:gl3_pkg::WF];
    rsum       = gl3_pkg::RSUM_BITS'(p_hi)
                 + gl3_pkg::RSUM_BITS'($signed({1'b0, low_part}));
    r          = rsum[gl3_pkg::RSUM_BITS-1:gl3_pkg::WF];
    // out of range when the bits above the sample do not all match its sign
    overflow   = (r[gl3_pkg::R_BITS-1:S-1] != '0) && (r[gl3_pkg::R_BITS-1:S-1] != '1);
    if (overflow) begin
      sat = r[gl3_pkg::R_BITS-1] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
    end else begin
      sat = r[S-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= job_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p_side <= $signed(job.side_sum) * $signed({1'b0, side_weight});
      p_diag <= $signed(job.diag_sum) * $signed({1'b0, diagonal_weight});
      c1     <= job.centre;
      e1     <= job.end_of_row;

      acc <= gl3_pkg::ACC_BITS'($signed({c1, {gl3_pkg::WF{1'b0}}}))
             + gl3_pkg::ACC_BITS'(p_side) + gl3_pkg::ACC_BITS'(p_diag);
      e2  <= e1;

      p_hi <= $signed(acc[gl3_pkg::ACC_BITS-1:gl3_pkg::WF]) * $signed({1'b0, norm_gain});
      p_lo <= acc[gl3_pkg::WF-1:0] * norm_gain;
      e3   <= e2;

      filtered_pixel <= sat;
      end_of_row     <= e3;
    end
  end

endmodule

// ----- src/gabor_like_3x3_row_filter.sv -----
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// -------   --------------------   ----------------------------------------------
// in        in_valid / in_stall    top_sample, centre_sample, bottom_sample,
//                                  last_in_row
// out       out_valid / out_stall  filtered_pixel, end_of_row
// config    wr_en                  wr_index, wr_data (no read-back)
//
// Sustains one column request per clock while in_stall is low. A last-in-row
// column that follows another column yields two results and holds in_stall
// until the second job is queued, as the front writes one job per cycle into
// the queue. The back pipeline is four register stages. Synchronous
// active-high reset clears control state and loads the default weights.
// out_stall while out_valid is high freezes the whole back pipeline; the
// four-entry job queue then fills and in_stall rises.

module gabor_like_3x3_row_filter (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [gl3_pkg::CFG_INDEX_BITS-1:0]    wr_index,
  input  logic [gl3_pkg::CFG_DATA_BITS-1:0]     wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  gl3_pkg::sample_t                      top_sample,
  input  gl3_pkg::sample_t                      centre_sample,
  input  gl3_pkg::sample_t                      bottom_sample,
  input  logic                                  last_in_row,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output gl3_pkg::sample_t                      filtered_pixel,
  output logic                                  end_of_row
);

  // Filter coefficients; the user must write them only while the block is idle, the block does not enforce it
  gl3_pkg::weight_t side_weight;
  gl3_pkg::weight_t diagonal_weight;
  gl3_pkg::gain_t   norm_gain;

  // Front to queue
  logic               job_push;
  gl3_pkg::filt_job_t job_in;
  logic               job_full;

  // Queue to back
  logic               job_pop;
  gl3_pkg::filt_job_t job_head;
  logic               job_avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_weight     <= gl3_pkg::SIDE_WEIGHT_RESET;
      diagonal_weight <= gl3_pkg::DIAGONAL_WEIGHT_RESET;
      norm_gain       <= gl3_pkg::NORM_GAIN_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        gl3_pkg::REG_SIDE_WEIGHT: begin
          side_weight <= wr_data[gl3_pkg::WEIGHT_BITS-1:0];
        end
        gl3_pkg::REG_DIAGONAL_WEIGHT: begin
          diagonal_weight <= wr_data[gl3_pkg::WEIGHT_BITS-1:0];
        end
        gl3_pkg::REG_NORM_GAIN: begin
          norm_gain <= wr_data[gl3_pkg::GAIN_BITS-1:0];
        end
        default: begin
          // unmapped index: write dropped
        end
      endcase
    end
  end

  // Front: holds the column window, turns each column into filter jobs
  gl3_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .top_sample    (top_sample),
    .centre_sample (centre_sample),
    .bottom_sample (bottom_sample),
    .last_in_row   (last_in_row),
    .job_full      (job_full),
    .job_push      (job_push),
    .job_data      (job_in)
  );

  // Short queue decoupling front from back
  gl3_job_fifo u_job_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .head      (job_head),
    .not_empty (job_avail)
  );

  // Back: weighting, gain, rounding and saturation
  gl3_back u_back (
    .clk             (clk),
    .rst             (rst),
    .job_valid       (job_avail),
    .job             (job_head),
    .job_pop         (job_pop),
    .side_weight     (side_weight),
    .diagonal_weight (diagonal_weight),
    .norm_gain       (norm_gain),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .filtered_pixel  (filtered_pixel),
    .end_of_row      (end_of_row)
  );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

// Column requests go in as top/centre/bottom samples with a row-end flag.
// Filtered centre-row pixels come out, one column behind.
// A predictor tracks the 3x3 window and queues the pixels it expects.
// A single monitor feeds it every accepted request and checks every
// accepted pixel against the oldest one queued.

module testbench;
  import gl3_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES    = 12;   // back pipeline is four stages deep

  // The map has three registers; the fourth index must be ignored.
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED = 2'd3;

  localparam sample_t S_MAX = sample_t'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam sample_t S_MIN = sample_t'(-(2 ** (SAMPLE_BITS - 1)));

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  typedef struct packed {
    sample_t pixel;
    logic    row_end;
  } filtered_result_t;

  // Predictor: own copy of the weights and the two-column window.
  class row_filter_predictor;
    longint           side_w;
    longint           diag_w;
    longint           gain;
    sample_t          left_t, left_c, left_b;   // column left of the pending one
    sample_t          mid_t, mid_c, mid_b;      // pending centre column
    int               columns;                  // 0 at row start, 1, then 2
    filtered_result_t expected_pixels[$];
    int               errors;

    function new();
      side_w  = SIDE_WEIGHT_RESET;
      diag_w  = DIAGONAL_WEIGHT_RESET;
      gain    = NORM_GAIN_RESET;
      left_t  = '0; left_c = '0; left_b = '0;
      mid_t   = '0; mid_c  = '0; mid_b  = '0;
      columns = 0;
      errors  = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_BITS-1:0] idx,
                               logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_SIDE_WEIGHT:     side_w = data[WEIGHT_BITS-1:0];
        REG_DIAGONAL_WEIGHT: diag_w = data[WEIGHT_BITS-1:0];
        REG_NORM_GAIN:       gain   = data[GAIN_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Kernel on one 3x3 window; args row by row, left to right.
    // floor((acc * gain + half) / 2^(2*WF)) is round-half-up, then clamp.
    function sample_t weigh_window(sample_t tl, sample_t tc, sample_t tr,
                                   sample_t cl, sample_t cc, sample_t cr,
                                   sample_t bl, sample_t bc, sample_t br);
      longint side;
      longint diag;
      longint acc;
      longint r;
      side = longint'(tc) + longint'(bc) + longint'(cl) + longint'(cr);
      diag = longint'(tl) + longint'(tr) + longint'(bl) + longint'(br);
      acc  = (longint'(cc) <<< WF) + side * side_w + diag * diag_w;
      r    = (acc * gain + (longint'(1) <<< (2 * WF - 1))) >>> (2 * WF);
      if (r > longint'(S_MAX)) r = longint'(S_MAX);
      if (r < longint'(S_MIN)) r = longint'(S_MIN);
      return sample_t'(r);
    endfunction

    function void expect_pixel(sample_t pixel, logic row_end);
      filtered_result_t res;
      res.pixel   = pixel;
      res.row_end = row_end;
      expected_pixels.push_back(res);
    endfunction

    // One accepted column request.
    function void note_request(sample_t t, sample_t c, sample_t b, logic last);
      if (columns == 0) begin
        // left edge repeats this column
        left_t = t; mid_t = t;
        left_c = c; mid_c = c;
        left_b = b; mid_b = b;
        if (last)
          expect_pixel(weigh_window(t, t, t, c, c, c, b, b, b), 1'b1);
        else
          columns = 1;
        return;
      end
      expect_pixel(weigh_window(left_t, mid_t, t, left_c, mid_c, c,
                                left_b, mid_b, b), 1'b0);
      left_t = mid_t; mid_t = t;
      left_c = mid_c; mid_c = c;
      left_b = mid_b; mid_b = b;
      columns = 2;
      if (last) begin
        // right edge repeats this column
        expect_pixel(weigh_window(left_t, t, t, left_c, c, c, left_b, b, b), 1'b1);
        columns = 0;
      end
    endfunction

    function void fault(string msg);
      errors++;
      $display("%s", msg);
    endfunction

    function void check_pixel(sample_t pixel, logic row_end);
      filtered_result_t want;
      if (expected_pixels.size() == 0) begin
        fault($sformatf("%0t ns: pixel %0d (end_of_row %0b) with nothing expected",
                        $time, pixel, row_end));
        return;
      end
      want = expected_pixels.pop_front();
      if (want.pixel !== pixel)
        fault($sformatf("%0t ns: filtered_pixel expected %0d, got %0d",
                        $time, want.pixel, pixel));
      if (want.row_end !== row_end)
        fault($sformatf("%0t ns: end_of_row expected %0b, got %0b",
                        $time, want.row_end, row_end));
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  // DUT signals; every input starts at a known value.
  logic                      clk           = 1'b0;
  logic                      rst           = 1'b1;
  logic                      wr_en         = 1'b0;
  logic [CFG_INDEX_BITS-1:0] wr_index      = '0;
  logic [CFG_DATA_BITS-1:0]  wr_data       = '0;
  logic                      in_valid      = 1'b0;
  logic                      in_stall;
  sample_t                   top_sample    = '0;
  sample_t                   centre_sample = '0;
  sample_t                   bottom_sample = '0;
  logic                      last_in_row   = 1'b0;
  logic                      out_valid;
  logic                      out_stall     = 1'b0;
  sample_t                   filtered_pixel;
  logic                      end_of_row;

  row_filter_predictor predictor = new();

  // Idling controls
  int          gap_max     = 0;
  int          burst_left  = 0;
  stall_mode_t stall_mode  = STALL_NONE;
  logic        holding     = 1'b0;
  int unsigned stall_count = 0;
  int unsigned cycle_count = 0;
  event        hold_off_ev;

  gabor_like_3x3_row_filter u_top (.*);

  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Monitor: both handshakes seen with pre-edge values.
  // A request is noted before a pixel is checked in the same cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        predictor.note_request(top_sample, centre_sample, bottom_sample, last_in_row);
      if (out_valid && !out_stall)
        predictor.check_pixel(filtered_pixel, end_of_row);
    end
  end

  // Receiver back-pressure: a per-phase pattern, plus an occasional long hold.
  always @(posedge clk) begin
    logic pattern;
    stall_count <= stall_count + 1;
    case (stall_mode)
      STALL_LIGHT:    pattern = ($urandom_range(0, 99) < 25);
      STALL_HEAVY:    pattern = ($urandom_range(0, 99) < 70);
      STALL_PERIODIC: pattern = ((stall_count % 9) < 4);
      default:        pattern = 1'b0;
    endcase
    out_stall <= holding || pattern;
  end

  // Long hold; counted here, while the sender keeps offering requests.
  initial begin
    forever begin
      @(hold_off_ev);
      holding <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clk);
      holding <= 1'b0;
    end
  end

  // Sample mix: rails, zero, all-ones, small values near zero, full range
  function automatic sample_t rand_sample();
    case ($urandom_range(0, 15))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      3:       return sample_t'(-1);
      4, 5, 6: return sample_t'(int'($urandom_range(0, 1023)) - 512);
      default: return sample_t'($urandom());
    endcase
  endfunction

  // Mostly short rows, some medium, a few long ones.
  function automatic int row_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return $urandom_range(1, 6);
    if (pick < 95) return $urandom_range(7, 40);
    return $urandom_range(41, 160);
  endfunction

  // Gain that properly normalises the kernel: 1/(1 + 4*side + 4*diag) in Q1.16.
  function automatic logic [GAIN_BITS-1:0] matched_gain(longint sw, longint dw);
    longint den;
    den = (longint'(1) <<< WF) + 4 * sw + 4 * dw;
    return GAIN_BITS'(((longint'(1) <<< (2 * WF)) + den / 2) / den);
  endfunction

  // Sender works in bursts; the gap falls before each new burst.
  task automatic send_column(input sample_t t, input sample_t c, input sample_t b,
                             input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    top_sample    <= t;
    centre_sample <= c;
    bottom_sample <= b;
    last_in_row   <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random_rows(input int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = row_length();
      for (int i = 0; i < len; i++)
        send_column(rand_sample(), rand_sample(), rand_sample(), i == len - 1);
      sent += len;
    end
  endtask

  // Stop requesting, wait for every pixel, then let the pipeline settle.
  // A clock edge passes first, so the monitor has noted the final request.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predictor.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // All three registers plus a stray write to the unmapped index.
  // Weight writes carry a random bit 16, which the block must drop.
  task automatic write_config(input longint sw, input longint dw,
                              input logic [GAIN_BITS-1:0] gain);
    logic [CFG_INDEX_BITS-1:0] idx [4];
    logic [CFG_DATA_BITS-1:0]  val [4];
    idx[0] = REG_SIDE_WEIGHT;     val[0] = {1'($urandom_range(0, 1)), WEIGHT_BITS'(sw)};
    idx[1] = REG_DIAGONAL_WEIGHT; val[1] = {1'($urandom_range(0, 1)), WEIGHT_BITS'(dw)};
    idx[2] = REG_NORM_GAIN;       val[2] = gain;
    idx[3] = REG_UNMAPPED;        val[3] = CFG_DATA_BITS'($urandom());
    for (int i = 0; i < 4; i++) begin
      wr_en    <= 1'b1;
      wr_index <= idx[i];
      wr_data  <= val[i];
      predictor.set_register(idx[i], val[i]);
      @(posedge clk);
    end
    wr_en <= 1'b0;
  endtask

  task automatic set_idling(input int gaps, input stall_mode_t mode);
    gap_max    = gaps;
    burst_left = 0;
    stall_mode <= mode;
  endtask

  // Reset weights: one-pixel rows, short rows, and a ramp across the range.
  task automatic edge_rows();
    send_column(S_MAX, S_MAX, S_MAX, 1'b1);
    send_column(S_MIN, S_MIN, S_MIN, 1'b1);
    send_column(S_MAX, S_MIN, '0, 1'b0);
    send_column(S_MIN, S_MAX, sample_t'(-1), 1'b1);
    send_column(sample_t'(1000), sample_t'(-1000), S_MAX, 1'b0);
    send_column(S_MIN, '0, S_MAX, 1'b0);
    send_column(sample_t'(-1), sample_t'(1), '0, 1'b1);
    for (int i = 0; i < 5; i++)
      send_column(sample_t'(i * 16000 - 32000), sample_t'(32000 - i * 16000),
                  sample_t'(i * 4096), i == 4);
  endtask

  // Maximum weights and unity gain: most results pinned to the rails.
  task automatic saturating_rows();
    send_column(S_MAX, S_MAX, S_MAX, 1'b1);
    send_column(S_MIN, S_MIN, S_MIN, 1'b1);
    send_column(S_MAX, S_MIN, S_MAX, 1'b0);
    send_column(S_MAX, S_MAX, S_MAX, 1'b0);
    send_column(S_MIN, S_MIN, S_MIN, 1'b1);
    send_column(sample_t'(4096), '0, sample_t'(-4096), 1'b0);
    send_column('0, sample_t'(1), '0, 1'b1);
  endtask

  initial begin
    longint sw;
    longint dw;
    logic [GAIN_BITS-1:0] gain;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset weights, no idling: the directed edge cases.
    set_idling(0, STALL_NONE);
    edge_rows();
    wait_idle();

    // Top of both weight registers, unity gain: positive and negative saturation.
    write_config(65535, 65535, GAIN_BITS'(65536));
    set_idling(3, STALL_LIGHT);
    saturating_rows();
    send_random_rows(150);
    wait_idle();

    // All zero: every pixel must come out as zero.
    write_config(0, 0, '0);
    set_idling(6, STALL_HEAVY);
    send_random_rows(100);
    wait_idle();

    // Zero weights, unity gain: the centre sample passes straight through.
    write_config(0, 0, GAIN_BITS'(65536));
    set_idling(0, STALL_PERIODIC);
    send_random_rows(150);

    // Random settings; one phase has a gain that does not match the weights.
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      sw   = $urandom_range(0, p[0] ? 65535 : 12000);
      dw   = $urandom_range(0, p[0] ? 65535 : 8000);
      gain = (p == 3) ? GAIN_BITS'($urandom_range(0, 65536)) : matched_gain(sw, dw);
      write_config(sw, dw, gain);
      set_idling((p == 0) ? 0 : $urandom_range(1, 10), stall_mode_t'(p % 4));
      if (p == 1) -> hold_off_ev;
      send_random_rows(250);
    end

    wait_idle();
    if (predictor.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
